// ----- design/sfpf_pkg.sv -----
// Package for the sync frame parser with Fletcher check.
// Holds the result type, event codes, register indexes and reset values.
// No dependencies.
package sfpf_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_WORD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'd1;

    localparam logic [15:0] SYNC_WORD_RESET  = 16'h62B5;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_REJECT   = 2'd2;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] message_id;
        logic [15:0] payload_length;
        logic [15:0] received_checksum;
        logic        checksum_ok;
        logic        last_of_frame;
    } result_t;

endpackage

// ----- design/sfpf_in_if.sv -----
// Request channel carrying one received byte.
// Plain valid/ready handshake; no dependencies.
interface sfpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- design/sfpf_out_if.sv -----
// Result channel of the frame parser.
// Depends on sfpf_pkg for the result type.
interface sfpf_out_if;
    logic             valid;
    logic             ready;
    sfpf_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/sync_frame_parser_fletcher.sv -----
// Top level of the sync frame parser with 8-bit Fletcher check.
// Depends on sfpf_pkg, sfpf_in_if and sfpf_out_if.
//
// One byte is taken per clock cycle while the skid entry is empty: the whole
// per-byte update of the parse state and running sums happens in the cycle the
// byte is accepted, and any result is registered in the output register, or in
// the one-entry skid stage behind it while that register holds an untaken one.
// The skid keeps the input open while a result waits; the input stalls only when
// both hold a result that has not been taken. While the skid entry is full every
// byte waits, including sync, id, length and checksum low bytes with no result.
module sync_frame_parser_fletcher (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    sfpf_in_if.sink                          rx,
    sfpf_out_if.source                       res
);
    import sfpf_pkg::*;

    localparam logic [3:0] PH_SYNC0   = 4'd0;
    localparam logic [3:0] PH_SYNC1   = 4'd1;
    localparam logic [3:0] PH_ID0     = 4'd2;
    localparam logic [3:0] PH_ID1     = 4'd3;
    localparam logic [3:0] PH_LEN0    = 4'd4;
    localparam logic [3:0] PH_LEN1    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CK0     = 4'd7;
    localparam logic [3:0] PH_CK1     = 4'd8;

    logic [15:0] sync_word_reg;
    logic [15:0] max_length_reg;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  ck_low_reg, ck_low_next;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    result_t     out_reg;
    result_t     skid_reg;

    result_t     result;
    logic        result_hit;
    logic        accept;
    logic        take;
    logic [7:0]  c;
    logic [7:0]  a_inc;
    logic [7:0]  b_inc;
    logic [15:0] rx_ck;
    logic [15:0] len_full;

    assign c        = rx.rx_byte;
    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;
    assign take     = out_valid_reg && res.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    assign a_inc    = sum_a_reg + c;
    assign b_inc    = sum_b_reg + a_inc;
    assign rx_ck    = {c, ck_low_reg};
    assign len_full = {c, len_reg[7:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        ck_low_next = ck_low_reg;
        result_hit  = 1'b0;
        result      = '0;
        result.message_id     = id_reg;
        result.payload_length = len_reg;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                phase_next = (c == sync_word_reg[15:8]) ? PH_ID0 : PH_SYNC0;
            end
            PH_ID0:
            begin
                sum_a_next = c;
                sum_b_next = c;
                id_next    = {8'd0, c};
                phase_next = PH_ID1;
            end
            PH_ID1:
            begin
                sum_a_next = a_inc;
                sum_b_next = b_inc;
                id_next    = {c, id_reg[7:0]};
                phase_next = PH_LEN0;
            end
            PH_LEN0:
            begin
                sum_a_next = a_inc;
                sum_b_next = b_inc;
                len_next   = {8'd0, c};
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                sum_a_next = a_inc;
                sum_b_next = b_inc;
                len_next   = len_full;
                if (len_full > max_length_reg)
                begin
                    phase_next = PH_SYNC0;
                    result_hit = 1'b1;
                    result.event_res      = EV_REJECT;
                    result.payload_length = len_full;
                    result.last_of_frame  = 1'b1;
                end
                else
                begin
                    rem_next   = len_full;
                    phase_next = (len_full != 16'd0) ? PH_PAYLOAD : PH_CK0;
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next = a_inc;
                sum_b_next = b_inc;
                rem_next   = rem_reg - 16'd1;
                if (rem_reg == 16'd1)
                begin
                    phase_next = PH_CK0;
                end
                result_hit = 1'b1;
                result.event_res  = EV_PAYLOAD;
                result.data_byte  = c;
                result.byte_index = len_reg - rem_reg;
            end
            PH_CK0:
            begin
                ck_low_next = c;
                phase_next  = PH_CK1;
            end
            PH_CK1:
            begin
                phase_next = PH_SYNC0;
                result_hit = 1'b1;
                result.event_res         = EV_COMPLETE;
                result.received_checksum = rx_ck;
                result.checksum_ok       = (rx_ck == {sum_b_reg, sum_a_reg});
                result.last_of_frame     = 1'b1;
            end
            default:
            begin
                phase_next = (c == sync_word_reg[7:0]) ? PH_SYNC1 : PH_SYNC0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg  <= SYNC_WORD_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_WORD:  sync_word_reg  <= cfg_data;
                CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC0;
            id_reg     <= '0;
            len_reg    <= '0;
            rem_reg    <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            ck_low_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            ck_low_reg <= ck_low_next;
        end
    end

    // output register and skid entry; skid drains first to keep order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept && result_hit;
            end
        end
        else if (accept && result_hit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (accept && result_hit)
        begin
            skid_reg <= result;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (rem_reg != 16'd0))
        else $error("payload phase with no bytes remaining");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result_hit && result.last_of_frame) |=> (phase_reg == PH_SYNC0))
        else $error("end of frame did not return to hunting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_PAYLOAD)) |-> (result_hit && !result.last_of_frame))
        else $error("payload byte without payload result");

endmodule

// ----- tb/sv/sfpf_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the sync frame parser: watches the register port and both
// channels, predicts each result and compares it field by field.
// Depends on sfpf_pkg.
module sfpf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             rx_valid,
    input  logic                             rx_ready,
    input  logic [7:0]                       rx_byte,
    input  logic                             res_valid,
    input  logic                             res_ready,
    input  sfpf_pkg::result_t                res_data,
    output int                               mismatches,
    output int                               events_due,
    output int                               payload_count,
    output int                               frame_count,
    output int                               bad_sum_count,
    output int                               reject_count
);
    import sfpf_pkg::*;

    typedef enum logic [3:0] {
        HUNT_LO, HUNT_HI, ID_LO, ID_HI, LEN_LO, LEN_HI, PAYLOAD, CK_LO, CK_HI
    } phase_e;

    logic [15:0] sync_word_q;
    logic [15:0] max_length_q;
    phase_e      phase;
    logic [15:0] frame_id;
    logic [15:0] frame_length;
    logic [15:0] bytes_left;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  ck_low;
    result_t     predicted_events[$];

    task automatic report(input string what, input logic [15:0] got_v,
                          input logic [15:0] want_v);
        mismatches++;
        if (mismatches <= 100)
        begin
            $display("%0t mismatch: %s got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v)
        begin
            report(what, got_v, want_v);
        end
    endtask

    function automatic void add_sum(input logic [7:0] c);
        sum_a = sum_a + c;
        sum_b = sum_b + sum_a;
    endfunction

    // advance the parse state by one byte; return 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] c, output result_t r);
        logic [15:0] rx_sum;
        bit          emit;
        emit = 1'b0;
        r = '0;
        case (phase)
            HUNT_HI:
            begin
                phase = (c == sync_word_q[15:8]) ? ID_LO : HUNT_LO;
            end
            ID_LO:
            begin
                sum_a = c;
                sum_b = c;
                frame_id = {8'h00, c};
                phase = ID_HI;
            end
            ID_HI:
            begin
                add_sum(c);
                frame_id[15:8] = c;
                phase = LEN_LO;
            end
            LEN_LO:
            begin
                add_sum(c);
                frame_length = {8'h00, c};
                phase = LEN_HI;
            end
            LEN_HI:
            begin
                add_sum(c);
                frame_length[15:8] = c;
                if (frame_length > max_length_q)
                begin
                    phase = HUNT_LO;
                    r.event_res = EV_REJECT;
                    r.last_of_frame = 1'b1;
                    emit = 1'b1;
                end
                else
                begin
                    bytes_left = frame_length;
                    phase = (frame_length != 16'd0) ? PAYLOAD : CK_LO;
                end
            end
            PAYLOAD:
            begin
                r.event_res = EV_PAYLOAD;
                r.data_byte = c;
                r.byte_index = frame_length - bytes_left;
                add_sum(c);
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                begin
                    phase = CK_LO;
                end
                emit = 1'b1;
            end
            CK_LO:
            begin
                ck_low = c;
                phase = CK_HI;
            end
            CK_HI:
            begin
                rx_sum = {c, ck_low};
                r.event_res = EV_COMPLETE;
                r.received_checksum = rx_sum;
                r.checksum_ok = (rx_sum == {sum_b, sum_a});
                r.last_of_frame = 1'b1;
                emit = 1'b1;
                phase = HUNT_LO;
            end
            default:
            begin
                phase = (c == sync_word_q[7:0]) ? HUNT_HI : HUNT_LO;
            end
        endcase
        r.message_id = frame_id;
        r.payload_length = frame_length;
        return emit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            sync_word_q = SYNC_WORD_RESET;
            max_length_q = MAX_LENGTH_RESET;
            phase = HUNT_LO;
            frame_id = '0;
            frame_length = '0;
            bytes_left = '0;
            sum_a = '0;
            sum_b = '0;
            ck_low = '0;
            predicted_events.delete();
            mismatches = 0;
            payload_count = 0;
            frame_count = 0;
            bad_sum_count = 0;
            reject_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SYNC_WORD)
                begin
                    sync_word_q = cfg_data;
                end
                else if (cfg_index == CFG_MAX_LENGTH)
                begin
                    max_length_q = cfg_data;
                end
            end
            if (rx_valid && rx_ready)
            begin
                if (parse_byte(rx_byte, want))
                begin
                    predicted_events.push_back(want);
                end
            end
            if (res_valid && res_ready)
            begin
                got = res_data;
                if (predicted_events.size() == 0)
                begin
                    report("result with none pending, event", 16'(got.event_res), 16'h0);
                end
                else
                begin
                    want = predicted_events.pop_front();
                    check_field("event_res", 16'(got.event_res), 16'(want.event_res));
                    check_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
                    check_field("byte_index", got.byte_index, want.byte_index);
                    check_field("message_id", got.message_id, want.message_id);
                    check_field("payload_length", got.payload_length, want.payload_length);
                    check_field("received_checksum", got.received_checksum,
                                want.received_checksum);
                    check_field("checksum_ok", 16'(got.checksum_ok), 16'(want.checksum_ok));
                    check_field("last_of_frame", 16'(got.last_of_frame),
                                16'(want.last_of_frame));
                    case (want.event_res)
                        EV_PAYLOAD:
                        begin
                            payload_count++;
                        end
                        EV_COMPLETE:
                        begin
                            frame_count++;
                            if (!want.checksum_ok)
                            begin
                                bad_sum_count++;
                            end
                        end
                        default:
                        begin
                            reject_count++;
                        end
                    endcase
                end
            end
        end
        events_due = predicted_events.size();
    end

endmodule

// ----- tb/sv/tb_sync_frame_parser_fletcher.sv -----
`timescale 1ns / 100ps
// Top of the frame parser testbench: clock, reset, register writes, byte
// stimulus and result back-pressure; all checking sits in sfpf_checker.
// Depends on sfpf_pkg, sfpf_in_if, sfpf_out_if and sync_frame_parser_fletcher.
module tb_sync_frame_parser_fletcher;
    import sfpf_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     events_due;
    int                     payload_count;
    int                     frame_count;
    int                     bad_sum_count;
    int                     reject_count;
    int                     bytes_taken;
    int                     settings;
    bit                     idle_on;
    bit                     long_hold;
    logic [15:0]            cur_sync;
    logic [15:0]            cur_max;

    sfpf_in_if  rx_ch();
    sfpf_out_if res_ch();

    sync_frame_parser_fletcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    sfpf_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_valid      (rx_ch.valid),
        .rx_ready      (rx_ch.ready),
        .rx_byte       (rx_ch.rx_byte),
        .res_valid     (res_ch.valid),
        .res_ready     (res_ch.ready),
        .res_data      (res_ch.data),
        .mismatches    (mismatches),
        .events_due    (events_due),
        .payload_count (payload_count),
        .frame_count   (frame_count),
        .bad_sum_count (bad_sum_count),
        .reject_count  (reject_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("Timeout: results did not drain");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rx_ch.valid && rx_ch.ready)
        begin
            bytes_taken <= bytes_taken + 1;
        end
    end

    // result side: random short stalls, one long hold on request
    initial
    begin
        int held;
        int span;
        res_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            span = 0;
            if (long_hold)
            begin
                span = 80;
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                span = $urandom_range(1, 6);
            end
            if (span != 0)
            begin
                res_ch.ready <= 1'b0;
                held = 0;
                while (held < span)
                begin
                    @(negedge clk);
                    held++;
                end
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int n;
        int mark;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 6);
            rx_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        mark = bytes_taken;
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do
        begin
            @(negedge clk);
        end
        while (bytes_taken == mark);
    endtask

    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input bit bad_sum, input bit flat);
        logic [7:0]  hdr[4];
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [15:0] ck;
        int          k;
        a = '0;
        b = '0;
        send_byte(cur_sync[7:0]);
        send_byte(cur_sync[15:8]);
        hdr = '{id[7:0], id[15:8], len[7:0], len[15:8]};
        foreach (hdr[i])
        begin
            send_byte(hdr[i]);
            a = a + hdr[i];
            b = b + a;
        end
        if (len <= cur_max)
        begin
            for (k = 0; k < len; k++)
            begin
                v = flat ? 8'hFF : 8'($urandom);
                send_byte(v);
                a = a + v;
                b = b + a;
            end
            ck = {b, a};
            if (bad_sum)
            begin
                ck = ck ^ (16'h1 << $urandom_range(0, 15));
            end
            send_byte(ck[7:0]);
            send_byte(ck[15:8]);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_SYNC_WORD)
        begin
            cur_sync = value;
        end
        else
        begin
            cur_max = value;
        end
    endtask

    // drop the request and wait until every predicted result has come back
    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (events_due != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] sync_w, input logic [15:0] max_len);
        settle();
        write_reg(CFG_SYNC_WORD, sync_w);
        write_reg(CFG_MAX_LENGTH, max_len);
        settings++;
    endtask

    task automatic run_traffic(input int quota);
        int          start;
        int          pick;
        int          cap;
        int          n;
        logic [15:0] len;
        start = bytes_taken;
        while (bytes_taken - start < quota)
        begin
            pick = $urandom_range(0, 99);
            cap = (cur_max < 24) ? cur_max : 24;
            if (pick < 10)
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom));
            end
            else if (pick < 16)
            begin
                send_byte(cur_sync[7:0]);
                send_byte(cur_sync[15:8] ^ (8'h1 << $urandom_range(0, 7)));
            end
            else if (pick < 26 && cur_max != 16'hFFFF)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    len = cur_max + 16'd1;
                end
                else
                begin
                    len = 16'($urandom_range(cur_max + 1, 16'hFFFF));
                end
                send_frame(16'($urandom), len, 1'b0, 1'b0);
            end
            else
            begin
                len = 16'($urandom_range(0, cap));
                if (cur_max <= 64 && $urandom_range(0, 9) == 0)
                begin
                    len = cur_max;
                end
                send_frame(16'($urandom), len, $urandom_range(0, 3) == 0, 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        cur_sync = SYNC_WORD_RESET;
        cur_max = MAX_LENGTH_RESET;
        idle_on = 1'b1;
        long_hold = 1'b0;
        settings = 1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // zero-length frame, wrong second sync byte not retried, oversize
        // length, then one-byte frame with a bad checksum
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_byte(cur_sync[7:0]);
        send_byte(cur_sync[7:0]);
        send_byte(cur_sync[15:8]);
        send_frame(16'h1234, 16'hFFFF, 1'b0, 1'b0);
        send_frame(16'h0000, 16'h0001, 1'b1, 1'b1);

        run_traffic(170);
        long_hold = 1'b1;
        send_frame(16'($urandom), 16'd40, 1'b0, 1'b0);
        run_traffic(170);

        apply_settings(16'h0000, 16'h0000);
        run_traffic(200);
        apply_settings(16'hFFFF, 16'hFFFF);
        run_traffic(200);
        apply_settings(16'($urandom), 16'($urandom_range(1, 40)));
        run_traffic(300);
        apply_settings(SYNC_WORD_RESET, 16'd300);
        idle_on = 1'b0;
        run_traffic(350);
        settle();

        $display("Run: %0d bytes over %0d register settings; %0d payload bytes checked,",
                 bytes_taken, settings, payload_count);
        $display("%0d frames completed (%0d with a bad checksum), %0d lengths rejected.",
                 frame_count, bad_sum_count, reject_count);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
